FILE: rtl/lpcsd_pkg.sv
package lpcsd_pkg;

	localparam int ORDER      = 10;
	localparam int IDX_W      = $clog2(ORDER);
	localparam int CNT_W      = $clog2(ORDER + 1);
	localparam int HIST_W     = 24;
	localparam int COEF_W     = 16;
	localparam int COEF_IDX_W = 4;
	localparam int PITCH_W    = 8;
	localparam int GAIN_W     = 15;
	localparam int SEED_W     = 32;
	localparam int DEC_W      = 15;
	localparam int SAMPLE_W   = 16;
	localparam int Q_FRAC     = 12;

	localparam int RAD_W      = 2 * (2 * GAIN_W + PITCH_W) / 2;
	localparam int SQ_STEPS   = RAD_W / 2;
	localparam int SQ_CNT_W   = $clog2(SQ_STEPS);
	localparam int ROOT_W     = SQ_STEPS;
	localparam int REM_W      = ROOT_W + 2;
	localparam int AMP_W      = ROOT_W;
	localparam int E_W        = AMP_W + 1;
	localparam int ACC_W      = 48;

	localparam int MA_W       = SEED_W + 1;
	localparam int MB_W       = 25;
	localparam int PROD_W     = MA_W + MB_W;
	localparam int DM_W       = HIST_W + DEC_W + 1;
	localparam int NOISE_SH   = SEED_W - 1;

	localparam logic [SEED_W-1:0] LCG_MUL    = 32'd1664525;
	localparam logic [SEED_W-1:0] LCG_ADD    = 32'd1013904223;
	localparam logic [SEED_W-1:0] SEED_RESET = 32'h1234_5678;
	localparam logic [DEC_W-1:0]  DEEMPH_RESET = 15'd30720;
	localparam logic signed [DM_W-1:0] DEC_ROUND = DM_W'(1) <<< (DEC_W - 1);

	typedef enum logic [1:0] {
		OP_LOAD_COEF  = 2'd0,
		OP_LOAD_PITCH = 2'd1,
		OP_SYNTH      = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	function automatic logic signed [HIST_W-1:0] sat_hist(input logic signed [ACC_W-1:0] x);
		logic signed [HIST_W-1:0] r;
		if (&x[ACC_W-1:HIST_W-1] || ~|x[ACC_W-1:HIST_W-1]) begin
			r = x[HIST_W-1:0];
		end else if (x[ACC_W-1]) begin
			r = {1'b1, {(HIST_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(HIST_W-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [HIST_W-1:0] x);
		logic signed [SAMPLE_W-1:0] r;
		if (&x[HIST_W-1:SAMPLE_W-1] || ~|x[HIST_W-1:SAMPLE_W-1]) begin
			r = x[SAMPLE_W-1:0];
		end else if (x[HIST_W-1]) begin
			r = {1'b1, {(SAMPLE_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(SAMPLE_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

FILE: rtl/lpc_synthesis_decoder.sv
// LPC speech synthesizer, one operation per input transaction. Operation 0
// writes one Q4.12 predictor coefficient. Operation 1 loads gain and pitch
// and forms the impulse amplitude floor(gain*sqrt(pitch)): two multiplies
// and a one-bit-per-cycle square root; an unvoiced load (pitch 0) skips
// them. Operation 2 gives one 16-bit sample; one shared 33x25 multiplier
// serves the amplitude, the noise generator, every filter tap and the
// de-emphasis, and the coefficients and the filter history sit in memories
// that give one registered read per cycle, so the taps are visited one per
// cycle. A finished sample waits in the output register while the next
// transaction is taken; the block handles one transaction at a time.
// Reset clears the memories through per-entry valid bits, with no sweep.
module lpc_synthesis_decoder (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           operation,
	input  logic [lpcsd_pkg::COEF_IDX_W-1:0]     coef_index,
	input  logic signed [lpcsd_pkg::COEF_W-1:0]  value,
	input  logic [lpcsd_pkg::PITCH_W-1:0]        pitch,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic signed [lpcsd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lpcsd_pkg::DEC_W-1:0]          deemphasis_coeff
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_GG,
		ST_GP,
		ST_SQ_LOAD,
		ST_SQ,
		ST_LCG,
		ST_SEED,
		ST_NOISE,
		ST_NE,
		ST_TAP,
		ST_FILT,
		ST_DEEMPH,
		ST_OUT
	} state_t;

	state_t state_q;

	logic signed [lpcsd_pkg::COEF_W-1:0] coef_mem [lpcsd_pkg::ORDER];
	logic signed [lpcsd_pkg::HIST_W-1:0] hist_mem [lpcsd_pkg::ORDER];
	logic [lpcsd_pkg::ORDER-1:0]         coef_vld_q;
	logic [lpcsd_pkg::ORDER-1:0]         hist_vld_q;

	logic [lpcsd_pkg::GAIN_W-1:0]        gain_q;
	logic [lpcsd_pkg::PITCH_W-1:0]       pitch_q;
	logic [lpcsd_pkg::PITCH_W-1:0]       phase_q;
	logic [lpcsd_pkg::AMP_W-1:0]         amp_q;
	logic [lpcsd_pkg::SEED_W-1:0]        seed_q;
	logic signed [lpcsd_pkg::HIST_W-1:0] last_q;
	logic [lpcsd_pkg::DEC_W-1:0]         coeff_q;
	logic [lpcsd_pkg::IDX_W-1:0]         hp_q;
	logic [lpcsd_pkg::IDX_W-1:0]         rp_q;
	logic [lpcsd_pkg::CNT_W-1:0]         k_q;
	logic [lpcsd_pkg::SQ_CNT_W-1:0]      sq_cnt_q;
	logic                                v_s1;
	logic                                v_s2;
	logic                                cv_s1;
	logic                                hv_s1;
	logic                                out_valid_q;
	logic signed [lpcsd_pkg::SAMPLE_W-1:0] sample_q;

	logic signed [lpcsd_pkg::COEF_W-1:0] coef_rd_s1;
	logic signed [lpcsd_pkg::HIST_W-1:0] hist_rd_s1;
	logic signed [lpcsd_pkg::PROD_W-1:0] prod_q;
	logic signed [lpcsd_pkg::ACC_W-1:0]  acc_q;
	logic signed [lpcsd_pkg::HIST_W-1:0] y_q;
	logic [lpcsd_pkg::RAD_W-1:0]         rad_q;
	logic [lpcsd_pkg::REM_W-1:0]         rem_q;
	logic [lpcsd_pkg::ROOT_W-1:0]        root_q;

	logic                                in_fire;
	logic                                coef_we;
	logic [lpcsd_pkg::IDX_W-1:0]         coef_wa;
	logic [lpcsd_pkg::IDX_W-1:0]         hp_nx;
	logic [lpcsd_pkg::IDX_W-1:0]         rp_nx;
	logic [lpcsd_pkg::PITCH_W:0]         ph_inc;
	logic                                ph_hit;
	logic signed [lpcsd_pkg::MA_W-1:0]   a_mul;
	logic signed [lpcsd_pkg::MB_W-1:0]   b_mul;
	logic signed [lpcsd_pkg::PROD_W-1:0] prod_d;
	logic signed [lpcsd_pkg::E_W-1:0]    e_d;
	logic signed [lpcsd_pkg::ACC_W-1:0]  acc_init;
	logic signed [lpcsd_pkg::HIST_W-1:0] y_d;
	logic signed [lpcsd_pkg::DM_W-1:0]   dm_d;
	logic signed [lpcsd_pkg::DM_W-1:0]   dsh_d;
	logic signed [lpcsd_pkg::HIST_W-1:0] d_d;
	logic [lpcsd_pkg::REM_W-1:0]         rem_sh;
	logic [lpcsd_pkg::REM_W-1:0]         trial;
	logic                                sq_ge;
	logic [lpcsd_pkg::ROOT_W-1:0]        root_nx;
	logic                                tap_done;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	assign coef_we = in_fire && (operation == lpcsd_pkg::OP_LOAD_COEF) &&
		(coef_index != '0) && (int'(coef_index) <= lpcsd_pkg::ORDER);
	assign coef_wa = lpcsd_pkg::IDX_W'(coef_index - lpcsd_pkg::COEF_IDX_W'(1));

	assign hp_nx = (int'(hp_q) == lpcsd_pkg::ORDER - 1) ? '0 : hp_q + 1'b1;
	assign rp_nx = (rp_q == '0) ? lpcsd_pkg::IDX_W'(lpcsd_pkg::ORDER - 1) : rp_q - 1'b1;

	assign ph_inc = {1'b0, phase_q} + 1'b1;
	assign ph_hit = ph_inc >= {1'b0, pitch_q};

	// excitation for the current sample
	always_comb begin
		if (state_q == ST_NE) begin
			e_d = $signed(prod_q[lpcsd_pkg::NOISE_SH +: lpcsd_pkg::E_W]);
		end else if (ph_hit) begin
			e_d = $signed({1'b0, amp_q});
		end else begin
			e_d = '0;
		end
	end

	// e * 4096 plus the rounding half
	assign acc_init = $signed({{(lpcsd_pkg::ACC_W - lpcsd_pkg::E_W - lpcsd_pkg::Q_FRAC)
		{e_d[lpcsd_pkg::E_W-1]}}, e_d, 1'b1, {(lpcsd_pkg::Q_FRAC - 1){1'b0}}});

	assign y_d = lpcsd_pkg::sat_hist(acc_q >>> lpcsd_pkg::Q_FRAC);

	assign dm_d  = $signed(prod_q[lpcsd_pkg::DM_W-1:0]) + lpcsd_pkg::DEC_ROUND;
	assign dsh_d = dm_d >>> lpcsd_pkg::DEC_W;
	assign d_d   = lpcsd_pkg::sat_hist(lpcsd_pkg::ACC_W'(y_q) + lpcsd_pkg::ACC_W'(dsh_d));

	assign rem_sh  = {rem_q[lpcsd_pkg::REM_W-3:0], rad_q[lpcsd_pkg::RAD_W-1 -: 2]};
	assign trial   = {root_q, 2'b01};
	assign sq_ge   = rem_sh >= trial;
	assign root_nx = {root_q[lpcsd_pkg::ROOT_W-2:0], sq_ge};

	assign tap_done = (int'(k_q) == lpcsd_pkg::ORDER) && !v_s1 && !v_s2;

	// shared multiplier operand select
	always_comb begin
		a_mul = '0;
		b_mul = '0;
		case (state_q)
			ST_GG: begin
				a_mul = lpcsd_pkg::MA_W'(gain_q);
				b_mul = lpcsd_pkg::MB_W'(gain_q);
			end
			ST_GP: begin
				a_mul = lpcsd_pkg::MA_W'(prod_q[2*lpcsd_pkg::GAIN_W-1:0]);
				b_mul = lpcsd_pkg::MB_W'(pitch_q);
			end
			ST_LCG: begin
				a_mul = lpcsd_pkg::MA_W'(seed_q);
				b_mul = lpcsd_pkg::MB_W'(lpcsd_pkg::LCG_MUL);
			end
			ST_NOISE: begin
				a_mul = lpcsd_pkg::MA_W'($signed(seed_q));
				b_mul = lpcsd_pkg::MB_W'(gain_q);
			end
			ST_TAP: begin
				if (v_s1 && hv_s1) begin
					a_mul = lpcsd_pkg::MA_W'(hist_rd_s1);
				end
				if (v_s1 && cv_s1) begin
					b_mul = lpcsd_pkg::MB_W'(coef_rd_s1);
				end
			end
			ST_FILT: begin
				a_mul = lpcsd_pkg::MA_W'(last_q);
				b_mul = lpcsd_pkg::MB_W'(coeff_q);
			end
			default: begin
				a_mul = '0;
				b_mul = '0;
			end
		endcase
	end

	assign prod_d = a_mul * b_mul;

	// coefficient and history memories
	always_ff @(posedge clk) begin
		if (coef_we) begin
			coef_mem[coef_wa] <= value;
		end
		if (state_q == ST_FILT) begin
			hist_mem[hp_nx] <= y_d;
		end
		coef_rd_s1 <= coef_mem[k_q[lpcsd_pkg::IDX_W-1:0]];
		hist_rd_s1 <= hist_mem[rp_q];
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		case (state_q)
			ST_IDLE: begin
				acc_q <= acc_init;
			end
			ST_NE: begin
				acc_q <= acc_init;
			end
			ST_TAP: begin
				if (v_s2) begin
					acc_q <= acc_q - $signed(prod_q[lpcsd_pkg::ACC_W-1:0]);
				end
			end
			ST_FILT: begin
				y_q <= y_d;
			end
			ST_SQ_LOAD: begin
				rad_q  <= prod_q[lpcsd_pkg::RAD_W-1:0];
				rem_q  <= '0;
				root_q <= '0;
			end
			ST_SQ: begin
				rad_q  <= {rad_q[lpcsd_pkg::RAD_W-3:0], 2'b00};
				rem_q  <= sq_ge ? rem_sh - trial : rem_sh;
				root_q <= root_nx;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			coef_vld_q  <= '0;
			hist_vld_q  <= '0;
			gain_q      <= '0;
			pitch_q     <= '0;
			phase_q     <= '0;
			amp_q       <= '0;
			seed_q      <= lpcsd_pkg::SEED_RESET;
			last_q      <= '0;
			coeff_q     <= lpcsd_pkg::DEEMPH_RESET;
			hp_q        <= lpcsd_pkg::IDX_W'(lpcsd_pkg::ORDER - 1);
			rp_q        <= '0;
			k_q         <= '0;
			sq_cnt_q    <= '0;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			cv_s1       <= 1'b0;
			hv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
			sample_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				coeff_q <= deemphasis_coeff;
			end
			if (coef_we) begin
				coef_vld_q[coef_wa] <= 1'b1;
			end
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				sample_q    <= lpcsd_pkg::sat_out(last_q);
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			v_s1  <= (state_q == ST_TAP) && (int'(k_q) < lpcsd_pkg::ORDER);
			v_s2  <= v_s1;
			cv_s1 <= coef_vld_q[k_q[lpcsd_pkg::IDX_W-1:0]];
			hv_s1 <= hist_vld_q[rp_q];
			case (state_q)
				ST_IDLE: begin
					k_q  <= '0;
					rp_q <= hp_q;
					if (in_fire) begin
						case (operation)
							lpcsd_pkg::OP_LOAD_PITCH: begin
								gain_q  <= value[lpcsd_pkg::COEF_W-1] ? '0 :
									value[lpcsd_pkg::GAIN_W-1:0];
								pitch_q <= pitch;
								if (pitch == '0) begin
									amp_q <= '0;
								end else begin
									state_q <= ST_GG;
								end
							end
							lpcsd_pkg::OP_SYNTH: begin
								if (pitch_q != '0) begin
									phase_q <= ph_hit ?
										lpcsd_pkg::PITCH_W'(ph_inc - {1'b0, pitch_q}) :
										ph_inc[lpcsd_pkg::PITCH_W-1:0];
									state_q <= ST_TAP;
								end else begin
									state_q <= ST_LCG;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_GG: begin
					state_q <= ST_GP;
				end
				ST_GP: begin
					state_q <= ST_SQ_LOAD;
				end
				ST_SQ_LOAD: begin
					sq_cnt_q <= '0;
					state_q  <= ST_SQ;
				end
				ST_SQ: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (int'(sq_cnt_q) == lpcsd_pkg::SQ_STEPS - 1) begin
						amp_q   <= root_nx;
						state_q <= ST_IDLE;
					end
				end
				ST_LCG: begin
					state_q <= ST_SEED;
				end
				ST_SEED: begin
					seed_q  <= prod_q[lpcsd_pkg::SEED_W-1:0] + lpcsd_pkg::LCG_ADD;
					state_q <= ST_NOISE;
				end
				ST_NOISE: begin
					state_q <= ST_NE;
				end
				ST_NE: begin
					state_q <= ST_TAP;
				end
				ST_TAP: begin
					if (int'(k_q) < lpcsd_pkg::ORDER) begin
						k_q  <= k_q + 1'b1;
						rp_q <= rp_nx;
					end
					if (tap_done) begin
						state_q <= ST_FILT;
					end
				end
				ST_FILT: begin
					hist_vld_q[hp_nx] <= 1'b1;
					hp_q    <= hp_nx;
					state_q <= ST_DEEMPH;
				end
				ST_DEEMPH: begin
					last_q  <= d_d;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: tb/lpcsd_checker.sv
module lpcsd_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	input  logic                                  in_ready,
	input  logic [1:0]                            operation,
	input  logic [lpcsd_pkg::COEF_IDX_W-1:0]      coef_index,
	input  logic signed [lpcsd_pkg::COEF_W-1:0]   value,
	input  logic [lpcsd_pkg::PITCH_W-1:0]         pitch,
	input  logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic signed [lpcsd_pkg::SAMPLE_W-1:0] sample,
	input  logic                                  cfg_valid,
	input  logic                                  cfg_ready,
	input  logic [lpcsd_pkg::DEC_W-1:0]           deemphasis_coeff,
	output int                                    fails,
	output int                                    outstanding
);
	import lpcsd_pkg::*;

	logic [DEC_W-1:0]            dec_coeff;
	longint                      lpc_coef [ORDER];
	longint                      lpc_hist [ORDER];
	longint                      dec_last;
	longint                      gain_q;
	longint                      amp_q;
	logic [PITCH_W-1:0]          period_q;
	logic [PITCH_W-1:0]          phase_q;
	logic [SEED_W-1:0]           seed_q;
	logic signed [SAMPLE_W-1:0]  sample_q [$];
	logic signed [SAMPLE_W-1:0]  want;
	int                          fail_cnt;

	function automatic longint clamp_signed(longint x, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi) begin
			return hi;
		end
		if (x < lo) begin
			return lo;
		end
		return x;
	endfunction

	// floor square root, one trial bit at a time from the top
	function automatic longint isqrt_floor(longint x);
		longint r;
		longint t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (longint'(1) << b);
			if (t * t <= x) begin
				r = t;
			end
		end
		return r;
	endfunction

	task automatic clear_model();
		dec_coeff = DEEMPH_RESET;
		for (int k = 0; k < ORDER; k++) begin
			lpc_coef[k] = 0;
			lpc_hist[k] = 0;
		end
		dec_last = 0;
		gain_q   = 0;
		amp_q    = 0;
		period_q = '0;
		phase_q  = '0;
		seed_q   = SEED_RESET;
		sample_q.delete();
	endtask

	task automatic apply_item(logic [1:0] op, logic [COEF_IDX_W-1:0] idx,
			logic signed [COEF_W-1:0] val, logic [PITCH_W-1:0] pit);
		longint              e;
		longint              acc;
		longint              y;
		longint              d;
		logic [PITCH_W:0]    ph;
		logic signed [31:0]  r;
		case (op_t'(op))
			OP_LOAD_COEF: begin
				if (idx >= 1 && idx <= ORDER) begin
					lpc_coef[idx - 1] = val;
				end
			end
			OP_LOAD_PITCH: begin
				gain_q   = (val < 0) ? 0 : longint'(val);
				period_q = pit;
				amp_q    = (pit != 0) ? isqrt_floor(gain_q * gain_q * longint'(pit)) : 0;
			end
			OP_SYNTH: begin
				if (period_q != 0) begin
					ph = {1'b0, phase_q} + 1'b1;
					e  = 0;
					if (ph >= {1'b0, period_q}) begin
						ph = ph - {1'b0, period_q};
						e  = amp_q;
					end
					phase_q = ph[PITCH_W-1:0];
				end else begin
					seed_q = seed_q * LCG_MUL + LCG_ADD;
					r      = seed_q;
					e      = (longint'(r) * gain_q) >>> 31;
				end
				acc = e * 4096;
				for (int k = 0; k < ORDER; k++) begin
					acc -= lpc_coef[k] * lpc_hist[k];
				end
				y = clamp_signed((acc + 2048) >>> Q_FRAC, HIST_W);
				for (int k = ORDER - 1; k > 0; k--) begin
					lpc_hist[k] = lpc_hist[k - 1];
				end
				lpc_hist[0] = y;
				d = clamp_signed(y + ((longint'(dec_coeff) * dec_last + 16384) >>> 15), HIST_W);
				dec_last = d;
				sample_q.push_back(SAMPLE_W'(clamp_signed(d, SAMPLE_W)));
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_model();
			fail_cnt = 0;
			fails       <= 0;
			outstanding <= 0;
		end else begin
			// result first, so a transaction taken at the same edge queues behind it
			if (out_valid && out_ready) begin
				if (sample_q.size() == 0) begin
					$error("sample with no expectation: actual %0d", sample);
					fail_cnt++;
				end else begin
					want = sample_q.pop_front();
					if (sample !== want) begin
						$error("sample mismatch: expected %0d actual %0d", want, sample);
						fail_cnt++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				dec_coeff = deemphasis_coeff;
			end
			if (in_valid && in_ready) begin
				apply_item(operation, coef_index, value, pitch);
			end
			outstanding <= sample_q.size();
			fails       <= fail_cnt;
		end
	end

endmodule

FILE: tb/tb_lpc_synthesis_decoder.sv
module tb_lpc_synthesis_decoder;
	import lpcsd_pkg::*;

	logic                         clk;
	logic                         arst_n           = 1'b0;
	logic                         in_valid         = 1'b0;
	logic [1:0]                   operation        = '0;
	logic [COEF_IDX_W-1:0]        coef_index       = '0;
	logic signed [COEF_W-1:0]     value            = '0;
	logic [PITCH_W-1:0]           pitch            = '0;
	logic                         out_ready        = 1'b0;
	logic                         cfg_valid        = 1'b0;
	logic [DEC_W-1:0]             deemphasis_coeff = '0;
	wire                          in_ready;
	wire                          out_valid;
	wire                          cfg_ready;
	wire signed [SAMPLE_W-1:0]    sample;
	int                           fails;
	int                           outstanding;
	logic                         steady           = 1'b0;
	int                           sent             = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	lpc_synthesis_decoder DUT (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.coef_index       (coef_index),
		.value            (value),
		.pitch            (pitch),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample           (sample),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.deemphasis_coeff (deemphasis_coeff)
	);

	lpcsd_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.operation        (operation),
		.coef_index       (coef_index),
		.value            (value),
		.pitch            (pitch),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.sample           (sample),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.deemphasis_coeff (deemphasis_coeff),
		.fails            (fails),
		.outstanding      (outstanding)
	);

	always @(posedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 23);
	end

	task automatic send_item(logic [1:0] op, logic [COEF_IDX_W-1:0] idx,
			logic [COEF_W-1:0] val, logic [PITCH_W-1:0] pit);
		while (!steady && $urandom_range(0, 99) < 23) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		operation  <= op;
		coef_index <= idx;
		value      <= val;
		pitch      <= pit;
		do @(posedge clk); while (!in_ready);
		if (!(op == OP_NONE || (op == OP_LOAD_COEF && (idx == 0 || idx > ORDER)))) begin
			sent++;
		end
	endtask

	// hold off until every sample has come, then let a load finish
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_deemph(logic [DEC_W-1:0] v);
		cfg_valid        <= 1'b1;
		deemphasis_coeff <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [COEF_W-1:0] pick_coef(int style);
		int c;
		case (style)
			0:       c = $urandom_range(0, 1200) - 600;
			1:       c = $urandom_range(0, 8192) - 4096;
			default: c = $urandom_range(0, 65535) - 32768;
		endcase
		return COEF_W'(c);
	endfunction

	task automatic run_frame();
		int                    style;
		int                    n;
		int                    pick;
		logic [COEF_W-1:0]     g;
		logic [PITCH_W-1:0]    p;
		if ($urandom_range(0, 99) < 15) begin
			send_item(2'($urandom_range(0, 3)), 4'($urandom_range(0, 15)),
				16'($urandom), 8'($urandom));
		end else begin
			style = $urandom_range(0, 5) < 3 ? 0 : $urandom_range(1, 2);
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 3)) begin
					send_item(OP_LOAD_COEF, 4'($urandom_range(1, ORDER)), pick_coef(style),
						8'($urandom));
				end
			end else begin
				for (int k = 1; k <= ORDER; k++) begin
					send_item(OP_LOAD_COEF, 4'(k), pick_coef(style), 8'($urandom));
				end
			end
			if ($urandom_range(0, 4) != 0) begin
				pick = $urandom_range(0, 9);
				if (pick == 0) begin
					g = 16'($urandom_range(32768, 65535));
				end else if (pick < 5) begin
					g = 16'($urandom_range(0, 2000));
				end else begin
					g = 16'($urandom_range(0, 32767));
				end
				pick = $urandom_range(0, 9);
				if (pick < 3) begin
					p = '0;
				end else if (pick < 6) begin
					p = 8'($urandom_range(1, 12));
				end else begin
					p = 8'($urandom_range(13, 255));
				end
				send_item(OP_LOAD_PITCH, 4'($urandom), g, p);
			end
			n = $urandom_range(4, 40);
			repeat (n) begin
				send_item(OP_SYNTH, 4'($urandom), 16'($urandom), 8'($urandom));
			end
		end
	endtask

	initial begin
		int target;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_NONE, 4'd15, 16'hFFFF, 8'hFF);
		send_item(OP_LOAD_COEF, 4'd0, 16'h7FFF, 8'h00);
		send_item(OP_LOAD_COEF, 4'd11, 16'h8000, 8'h00);
		send_item(OP_LOAD_COEF, 4'd1, 16'h8000, 8'h00);
		send_item(OP_LOAD_COEF, 4'd10, 16'h7FFF, 8'h00);
		// negative gain clamps to zero
		send_item(OP_LOAD_PITCH, 4'd0, 16'h8000, 8'h00);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_LOAD_PITCH, 4'd0, 16'h7FFF, 8'h00);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_LOAD_PITCH, 4'd0, 16'h7FFF, 8'hFF);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_LOAD_COEF, 4'd1, 16'h0000, 8'h00);
		send_item(OP_LOAD_COEF, 4'd10, 16'h0000, 8'h00);
		send_item(OP_LOAD_PITCH, 4'd0, 16'd1000, 8'd1);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_LOAD_PITCH, 4'd0, 16'd500, 8'd6);
		repeat (4) send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		// phase now beyond the shorter pitch
		send_item(OP_LOAD_PITCH, 4'd0, 16'd500, 8'd2);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		send_item(OP_SYNTH, 4'd0, 16'h0000, 8'h00);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0:       write_deemph('0);
				1:       write_deemph('1);
				3:       write_deemph(DEEMPH_RESET);
				4:       write_deemph(15'd1);
				default: write_deemph(15'($urandom));
			endcase
			steady <= (ph == 2);
			target = sent + 250;
			while (sent < target) begin
				run_frame();
			end
			drain();
		end

		if (fails == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
